// File: hdl/bfa_pkg.sv
// Shared types, sizes and codes for the best-fit block allocator.
// No dependencies; used by every module of the allocator.
package bfa_pkg;

	localparam int POOL_BYTES = 4096;
	localparam int HEADER     = 24;
	localparam int MAX_BLOCKS = 256;

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = IDX_W + 1;
	localparam int OFF_W  = $clog2(POOL_BYTES);
	localparam int SIZE_W = 13;
	localparam int ADDR_W = 32;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_INIT  = 2'd2;
	localparam logic [1:0] CMD_DONE  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FAIL     = 2'd1;
	localparam logic [1:0] ST_NOTREADY = 2'd2;
	localparam logic [1:0] ST_BADFREE  = 2'd3;

	localparam logic REG_BASE = 1'b0;
	localparam logic REG_SIZE = 1'b1;

	typedef struct packed {
		logic [OFF_W-1:0]  off;
		logic [SIZE_W-1:0] size;
		logic              used;
	} entry_t;

	// per-slot load select
	typedef struct packed {
		logic take_l;
		logic take_r;
		logic take_w;
	} slot_ctl_t;

	typedef enum logic [2:0] {
		TOP_HOLD,
		TOP_ROT,
		TOP_WR,
		TOP_INS,
		TOP_REM
	} tbl_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_A_CHK,
		S_A_WR,
		S_A_INS,
		S_F_CHK,
		S_F_W1,
		S_F_R1,
		S_F_P,
		S_F_W2,
		S_F_R2
	} state_t;

endpackage

// File: hdl/bfa_slot.sv
// One slot of the block table: holds a single entry and loads from a neighbor
// or the write bus. Depends on bfa_pkg.
module bfa_slot import bfa_pkg::*; (
	input  logic      clk,
	input  slot_ctl_t ctl,
	input  entry_t    left,
	input  entry_t    right,
	input  entry_t    wdata,
	output entry_t    q
);

	always_ff @(posedge clk) begin
		if (ctl.take_w) begin
			q <= wdata;
		end else if (ctl.take_r) begin
			q <= right;
		end else if (ctl.take_l) begin
			q <= left;
		end
	end

endmodule

// File: hdl/best_fit_block_allocator.sv
// Best-fit allocator top level: command sequencer over a ring of table slots.
// Depends on bfa_pkg and bfa_slot.
//
// channel   ports                                   handshake
// config    cfg_we cfg_idx cfg_wdata                write when cfg_we
// request   start cmd req_size address              taken when start && !busy
// result    result_strobe status alloc_address      one cycle, no stall
//
// init, done and requests rejected up front answer in the cycle after acceptance.
// Alloc and free rotate the whole slot ring once (one entry seen at the head per
// cycle), then step through states that check and edit the table; the result
// follows in the cycle after the last of them. Table edits write one slot or
// shift the slots from the edit index up, all at once. Reset clears control
// state only; the table contents are valid below the entry count.
module best_fit_block_allocator import bfa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [31:0]       cfg_wdata,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        cmd,
	input  logic [SIZE_W-1:0] req_size,
	input  logic [ADDR_W-1:0] address,
	output logic              result_strobe,
	output logic [1:0]        status,
	output logic [ADDR_W-1:0] alloc_address
);

	localparam logic [SIZE_W-1:0] HDR      = SIZE_W'(HEADER);
	localparam logic [SIZE_W-1:0] POOL_MAX = SIZE_W'(POOL_BYTES);

	state_t state_q, state_d;

	logic [ADDR_W-1:0] pool_base_q;
	logic [SIZE_W-1:0] pool_size_q;
	logic [CNT_W-1:0]  count_q;
	logic              ready_q;
	logic [CNT_W-1:0]  k_q;

	logic [1:0]        cmd_q;
	logic [SIZE_W-1:0] req_q;
	logic [ADDR_W-1:0] adr_q;

	logic              found_q;
	logic [IDX_W-1:0]  bidx_q;
	entry_t            bent_q;
	entry_t            last_q;
	entry_t            prev_q;
	logic              prev_ok_q;
	entry_t            next_q;
	logic              next_ok_q;
	logic              nxt_cap_q;
	logic              split_q;
	logic              merge_q;
	logic [SIZE_W-1:0] merged_q;

	tbl_op_t           op;
	logic [IDX_W-1:0]  widx;
	entry_t            wdat;
	logic              fin;
	logic [1:0]        fin_status;
	logic [ADDR_W-1:0] fin_addr;

	entry_t            slots [MAX_BLOCKS];
	entry_t            head;
	logic              vis;
	logic [ADDR_W-1:0] offd;
	logic              hit;
	logic [SIZE_W-1:0] init_sz;
	logic [SIZE_W-1:0] diff;

	assign head    = slots[0];
	assign vis     = k_q < count_q;
	assign offd    = adr_q - pool_base_q - ADDR_W'(HEADER);
	assign hit     = (offd[ADDR_W-1:OFF_W] == '0) && (head.off == offd[OFF_W-1:0]);
	assign init_sz = (pool_size_q > POOL_MAX) ? POOL_MAX : pool_size_q;
	assign diff    = bent_q.size - req_q;
	assign busy    = (state_q != S_IDLE);

	// slot ring
	for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_slot
		slot_ctl_t ctl;
		always_comb begin
			ctl = '0;
			case (op)
				TOP_ROT: ctl.take_r = 1'b1;
				TOP_WR:  ctl.take_w = (widx == IDX_W'(i));
				TOP_INS: begin
					ctl.take_w = (widx == IDX_W'(i));
					ctl.take_l = (IDX_W'(i) > widx);
				end
				TOP_REM: ctl.take_r = (IDX_W'(i) >= widx);
				default: ctl = '0;
			endcase
		end
		bfa_slot u_slot (
			.clk   (clk),
			.ctl   (ctl),
			.left  (slots[(i + MAX_BLOCKS - 1) % MAX_BLOCKS]),
			.right (slots[(i + 1) % MAX_BLOCKS]),
			.wdata (wdat),
			.q     (slots[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		op         = TOP_HOLD;
		widx       = '0;
		wdat       = '0;
		fin        = 1'b0;
		fin_status = ST_OK;
		fin_addr   = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (cmd)
						CMD_ALLOC: begin
							if (!ready_q) begin
								fin = 1'b1; fin_status = ST_NOTREADY;
							end else if (req_size == '0) begin
								fin = 1'b1; fin_status = ST_FAIL;
							end else begin
								state_d = S_SCAN;
							end
						end
						CMD_FREE: begin
							if (!ready_q) begin
								fin = 1'b1; fin_status = ST_NOTREADY;
							end else if (address == '0) begin
								fin = 1'b1;
							end else begin
								state_d = S_SCAN;
							end
						end
						CMD_INIT: begin
							fin = 1'b1;
							if (pool_base_q == '0 || init_sz <= HDR) begin
								fin_status = ST_FAIL;
							end else begin
								op        = TOP_WR;
								wdat.off  = '0;
								wdat.size = init_sz - HDR;
								wdat.used = 1'b0;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			S_SCAN: begin
				op = TOP_ROT;
				if (k_q == CNT_W'(MAX_BLOCKS - 1)) begin
					state_d = (cmd_q == CMD_ALLOC) ? S_A_CHK : S_F_CHK;
				end
			end
			S_A_CHK: begin
				if (!found_q) begin
					fin = 1'b1; fin_status = ST_FAIL;
					state_d = S_IDLE;
				end else begin
					state_d = S_A_WR;
				end
			end
			S_A_WR: begin
				op        = TOP_WR;
				widx      = bidx_q;
				wdat.off  = bent_q.off;
				wdat.size = split_q ? req_q : bent_q.size;
				wdat.used = 1'b1;
				fin_addr  = pool_base_q + ADDR_W'(bent_q.off) + ADDR_W'(HEADER);
				if (split_q) begin
					state_d = S_A_INS;
				end else begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_A_INS: begin
				op        = TOP_INS;
				widx      = bidx_q + 1'b1;
				wdat.off  = bent_q.off + OFF_W'(HEADER) + req_q[OFF_W-1:0];
				wdat.size = diff - HDR;
				wdat.used = 1'b0;
				fin       = 1'b1;
				fin_addr  = pool_base_q + ADDR_W'(bent_q.off) + ADDR_W'(HEADER);
				state_d   = S_IDLE;
			end
			S_F_CHK: begin
				if (!found_q || !bent_q.used) begin
					fin = 1'b1; fin_status = ST_BADFREE;
					state_d = S_IDLE;
				end else begin
					state_d = S_F_W1;
				end
			end
			S_F_W1: begin
				op        = TOP_WR;
				widx      = bidx_q;
				wdat.off  = bent_q.off;
				wdat.size = merged_q;
				wdat.used = 1'b0;
				state_d   = merge_q ? S_F_R1 : S_F_P;
			end
			S_F_R1: begin
				op      = TOP_REM;
				widx    = bidx_q + 1'b1;
				state_d = S_F_P;
			end
			S_F_P: begin
				if (prev_ok_q && !prev_q.used) begin
					state_d = S_F_W2;
				end else begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_F_W2: begin
				op        = TOP_WR;
				widx      = bidx_q - 1'b1;
				wdat.off  = prev_q.off;
				wdat.size = prev_q.size + merged_q + HDR;
				wdat.used = 1'b0;
				state_d   = S_F_R2;
			end
			S_F_R2: begin
				op      = TOP_REM;
				widx    = bidx_q;
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q   <= '0;
			pool_size_q   <= '0;
			count_q       <= '0;
			ready_q       <= 1'b0;
			k_q           <= '0;
			found_q       <= 1'b0;
			nxt_cap_q     <= 1'b0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= fin;
			if (cfg_we) begin
				case (cfg_idx)
					REG_BASE: pool_base_q <= cfg_wdata;
					REG_SIZE: pool_size_q <= cfg_wdata[SIZE_W-1:0];
					default:  pool_base_q <= pool_base_q;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					k_q       <= '0;
					found_q   <= 1'b0;
					nxt_cap_q <= 1'b0;
					if (start && cmd == CMD_DONE) begin
						ready_q <= 1'b0;
						count_q <= '0;
					end else if (start && cmd == CMD_INIT && op == TOP_WR) begin
						ready_q <= 1'b1;
						count_q <= CNT_W'(1);
					end
				end
				S_SCAN: begin
					k_q <= k_q + 1'b1;
					if (cmd_q == CMD_ALLOC) begin
						if (vis && !head.used && head.size >= req_q &&
						    (!found_q || head.size < bent_q.size)) begin
							found_q <= 1'b1;
						end
					end else if (vis && !found_q && hit) begin
						found_q   <= 1'b1;
						nxt_cap_q <= 1'b1;
					end else begin
						nxt_cap_q <= 1'b0;
					end
				end
				S_A_INS: count_q <= count_q + 1'b1;
				S_F_R1:  count_q <= count_q - 1'b1;
				S_F_R2:  count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// request and scan payload
	always_ff @(posedge clk) begin
		if (fin) begin
			status        <= fin_status;
			alloc_address <= fin_addr;
		end
		case (state_q)
			S_IDLE: begin
				cmd_q     <= cmd;
				req_q     <= req_size;
				adr_q     <= address;
				next_ok_q <= 1'b0;
			end
			S_SCAN: begin
				last_q <= head;
				if (cmd_q == CMD_ALLOC) begin
					if (vis && !head.used && head.size >= req_q &&
					    (!found_q || head.size < bent_q.size)) begin
						bidx_q <= k_q[IDX_W-1:0];
						bent_q <= head;
					end
				end else if (vis && !found_q && hit) begin
					bidx_q    <= k_q[IDX_W-1:0];
					bent_q    <= head;
					prev_q    <= last_q;
					prev_ok_q <= (k_q != '0);
				end else if (nxt_cap_q) begin
					next_q    <= head;
					next_ok_q <= vis;
				end
			end
			S_A_CHK: begin
				split_q <= (diff > HDR) && (count_q < CNT_W'(MAX_BLOCKS));
			end
			S_F_CHK: begin
				merge_q  <= next_ok_q && !next_q.used;
				merged_q <= (next_ok_q && !next_q.used) ?
				            bent_q.size + next_q.size + HDR : bent_q.size;
			end
			default: merge_q <= merge_q;
		endcase
	end

endmodule

// File: hdl/bfa_checker.sv
// Port-level checks for the best-fit allocator, bound to the top level.
// Depends on bfa_pkg.
module bfa_checker import bfa_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              result_strobe,
	input logic [1:0]        status,
	input logic [ADDR_W-1:0] alloc_address
);

	a_resp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy) || $past(start && !busy))
		else $error("result without request");

	a_idle_on_resp: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> !busy)
		else $error("busy during result");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && status != ST_OK) |-> alloc_address == '0)
		else $error("address on failed request");

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without request");

endmodule

bind best_fit_block_allocator bfa_checker u_bfa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.status        (status),
	.alloc_address (alloc_address)
);

// File: tb/sv/testbench.sv
// Self-checking testbench for best_fit_block_allocator: directed table, then random phases.
// Holds its own block-table predictor, which is checked against the strobed results.
// Depends on bfa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module testbench;
	import bfa_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 300;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 200;

	typedef enum logic [1:0] {ROW_REQ, ROW_BASE, ROW_SIZE} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  op;
		logic [12:0] size;
		logic [31:0] arg;
		bit          pinned;
		logic [1:0]  st;
		logic [31:0] aa;
	} row_t;

	typedef struct {
		logic [1:0]  st;
		logic [31:0] aa;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_idx = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] cmd = CMD_DONE;
	logic [SIZE_W-1:0] req_size = '0;
	logic [ADDR_W-1:0] address = '0;
	logic result_strobe;
	logic [1:0] status;
	logic [ADDR_W-1:0] alloc_address;

	best_fit_block_allocator i_dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [31:0] m_base, m_size;
	logic [31:0] blk_off [MAX_BLOCKS];
	logic [31:0] blk_size [MAX_BLOCKS];
	bit          blk_used [MAX_BLOCKS];
	int          blk_count;
	bit          m_ready;

	outcome_t    pending [$];
	logic [31:0] live [$];
	int          errors = 0;

	bit          pin_on = 0;
	outcome_t    pin_val;

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void drop_blk(int idx);
		for (int k = idx; k + 1 < blk_count; k++) begin
			blk_off[k] = blk_off[k+1];
			blk_size[k] = blk_size[k+1];
			blk_used[k] = blk_used[k+1];
		end
		blk_count--;
	endfunction

	function automatic void add_blk(int idx, logic [31:0] off, logic [31:0] sz);
		for (int k = blk_count; k > idx; k--) begin
			blk_off[k] = blk_off[k-1];
			blk_size[k] = blk_size[k-1];
			blk_used[k] = blk_used[k-1];
		end
		blk_off[idx] = off;
		blk_size[idx] = sz;
		blk_used[idx] = 0;
		blk_count++;
	endfunction

	function automatic outcome_t allocate(logic [31:0] req);
		outcome_t r;
		int best;
		r = '{ST_OK, 32'd0};
		best = -1;
		if (!m_ready) begin
			r.st = ST_NOTREADY;
			return r;
		end
		for (int k = 0; k < blk_count; k++)
			if (!blk_used[k] && blk_size[k] >= req && (best < 0 || blk_size[k] < blk_size[best]))
				best = k;
		if (req == 0 || best < 0) begin
			r.st = ST_FAIL;
			return r;
		end
		if (blk_size[best] - req > HEADER && blk_count < MAX_BLOCKS) begin
			add_blk(best + 1, blk_off[best] + HEADER + req, blk_size[best] - req - HEADER);
			blk_size[best] = req;
		end
		blk_used[best] = 1;
		r.aa = m_base + blk_off[best] + HEADER;
		return r;
	endfunction

	function automatic outcome_t release_blk(logic [31:0] a);
		outcome_t r;
		logic [31:0] off;
		int k;
		r = '{ST_OK, 32'd0};
		if (!m_ready) begin
			r.st = ST_NOTREADY;
			return r;
		end
		if (a == 0)
			return r;
		off = a - m_base - HEADER;
		for (k = 0; k < blk_count; k++)
			if (blk_off[k] == off)
				break;
		if (k >= blk_count || !blk_used[k]) begin
			r.st = ST_BADFREE;
			return r;
		end
		blk_used[k] = 0;
		if (k + 1 < blk_count && !blk_used[k+1]) begin
			blk_size[k] += blk_size[k+1] + HEADER;
			drop_blk(k + 1);
		end
		if (k > 0 && !blk_used[k-1]) begin
			blk_size[k-1] += blk_size[k] + HEADER;
			drop_blk(k);
		end
		return r;
	endfunction

	function automatic outcome_t predict_request(logic [1:0] op, logic [12:0] sz, logic [31:0] a);
		outcome_t r;
		logic [31:0] psz;
		r = '{ST_OK, 32'd0};
		case (op)
			CMD_ALLOC: r = allocate({19'd0, sz});
			CMD_FREE: r = release_blk(a);
			CMD_INIT: begin
				psz = (m_size > POOL_BYTES) ? POOL_BYTES : m_size;
				if (m_base == 0 || psz <= HEADER) begin
					r.st = ST_FAIL;
				end else begin
					blk_off[0] = 0;
					blk_size[0] = psz - HEADER;
					blk_used[0] = 0;
					blk_count = 1;
					m_ready = 1;
				end
			end
			default: begin
				m_ready = 0;
				blk_count = 0;
			end
		endcase
		return r;
	endfunction

	// monitor: config writes, result checks, request prediction
	always @(posedge clk) begin
		outcome_t e;
		if (!arst_n) begin
			m_base = 0;
			m_size = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_BASE)
					m_base = cfg_wdata;
				else
					m_size = cfg_wdata & 32'h1FFF;
			end
			if (result_strobe) begin
				if (pending.size() == 0) begin
					report("unexpected result", {30'd0, status}, 32'd0);
				end else begin
					e = pending.pop_front();
					if (status !== e.st)
						report("status", {30'd0, status}, {30'd0, e.st});
					if (alloc_address !== e.aa)
						report("alloc_address", alloc_address, e.aa);
				end
			end
			if (start && !busy) begin
				e = predict_request(cmd, req_size, address);
				if (pin_on)
					pending.push_back(pin_val);
				else
					pending.push_back(e);
				if (cmd == CMD_ALLOC && e.st == ST_OK)
					live.push_back(e.aa);
				if (cmd == CMD_FREE && e.st == ST_OK)
					foreach (live[i])
						if (live[i] == address) begin
							live.delete(i);
							break;
						end
				if (cmd == CMD_INIT && e.st == ST_OK || cmd == CMD_DONE)
					live.delete();
			end
		end
	end

	// watchdog on cycles with no request taken and no result
	int quiet = 0;
	always @(posedge clk) begin
		if ((start && !busy) || result_strobe)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic issue(logic [1:0] op, logic [12:0] sz, logic [31:0] a,
		bit pinned = 0, logic [1:0] pst = ST_OK, logic [31:0] paa = 0);
		@(negedge clk);
		start = 1'b1;
		cmd = op;
		req_size = sz;
		address = a;
		pin_on = pinned;
		pin_val = '{pst, paa};
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(int n);
		@(negedge clk);
		start = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic set_reg(logic idx, logic [31:0] data);
		@(negedge clk);
		start = 1'b0;
		while (pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [12:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 13'($urandom_range(1, 120));
		if (r < 90) return 13'($urandom_range(1, 900));
		if (r < 95) return 13'($urandom_range(0, 8191));
		return (r < 97) ? 13'd0 : 13'd4072;
	endfunction

	function automatic logic [31:0] pick_base();
		case ($urandom_range(0, 5))
			0: return 32'hFFFF_FFFF;
			1: return 32'hFFFF_FFF0;
			2: return 32'd1;
			3: return 32'd0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [12:0] pick_pool();
		case ($urandom_range(0, 7))
			0: return 13'd4096;
			1: return 13'h1FFF;
			2: return 13'd25;
			3: return 13'd24;
			4: return 13'($urandom_range(0, 8191));
			default: return 13'($urandom_range(200, 4096));
		endcase
	endfunction

	row_t dir_tab [$];

	initial begin
		int r;
		logic [31:0] a;
		bit quiet_tail;
		m_base = 0;
		m_size = 0;
		blk_count = 0;
		m_ready = 0;

		dir_tab = '{
			'{ROW_REQ, CMD_ALLOC, 13'd16, 32'd0, 1, ST_NOTREADY, 32'd0},
			'{ROW_REQ, CMD_FREE, 13'd0, 32'h1234, 1, ST_NOTREADY, 32'd0},
			'{ROW_REQ, CMD_DONE, 13'd0, 32'd0, 1, ST_OK, 32'd0},
			'{ROW_REQ, CMD_INIT, 13'd0, 32'd0, 1, ST_FAIL, 32'd0},
			'{ROW_BASE, CMD_DONE, 13'd0, 32'h0000_1000, 0, ST_OK, 32'd0},
			'{ROW_SIZE, CMD_DONE, 13'd0, 32'd24, 0, ST_OK, 32'd0},
			'{ROW_REQ, CMD_INIT, 13'd0, 32'd0, 1, ST_FAIL, 32'd0},
			'{ROW_SIZE, CMD_DONE, 13'd0, 32'h1FFF, 0, ST_OK, 32'd0},
			'{ROW_REQ, CMD_INIT, 13'd0, 32'd0, 1, ST_OK, 32'd0},
			'{ROW_REQ, CMD_ALLOC, 13'd0, 32'd0, 1, ST_FAIL, 32'd0},
			'{ROW_REQ, CMD_ALLOC, 13'd4096, 32'd0, 1, ST_FAIL, 32'd0},
			'{ROW_REQ, CMD_ALLOC, 13'd4072, 32'd0, 1, ST_OK, 32'h0000_1018},
			'{ROW_REQ, CMD_FREE, 13'd0, 32'h0000_1018, 1, ST_OK, 32'd0},
			'{ROW_REQ, CMD_FREE, 13'd0, 32'h0000_1018, 1, ST_BADFREE, 32'd0},
			'{ROW_REQ, CMD_FREE, 13'd0, 32'd0, 1, ST_OK, 32'd0},
			'{ROW_REQ, CMD_ALLOC, 13'd100, 32'd0, 0, ST_OK, 32'd0},
			'{ROW_REQ, CMD_ALLOC, 13'd200, 32'd0, 0, ST_OK, 32'd0},
			'{ROW_REQ, CMD_ALLOC, 13'd50, 32'd0, 0, ST_OK, 32'd0},
			'{ROW_REQ, CMD_FREE, 13'd0, 32'h0000_1018, 0, ST_OK, 32'd0},
			'{ROW_REQ, CMD_FREE, 13'd0, 32'h0000_1158, 0, ST_OK, 32'd0},
			'{ROW_REQ, CMD_ALLOC, 13'd90, 32'd0, 0, ST_OK, 32'd0},
			'{ROW_REQ, CMD_FREE, 13'd0, 32'hFFFF_FFFF, 0, ST_OK, 32'd0},
			'{ROW_REQ, CMD_INIT, 13'd0, 32'd0, 1, ST_OK, 32'd0},
			'{ROW_REQ, CMD_DONE, 13'd0, 32'd0, 1, ST_OK, 32'd0},
			'{ROW_REQ, CMD_ALLOC, 13'd1, 32'd0, 1, ST_NOTREADY, 32'd0}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			case (dir_tab[i].kind)
				ROW_BASE: set_reg(REG_BASE, dir_tab[i].arg);
				ROW_SIZE: set_reg(REG_SIZE, dir_tab[i].arg);
				default: issue(dir_tab[i].op, dir_tab[i].size, dir_tab[i].arg,
					dir_tab[i].pinned, dir_tab[i].st, dir_tab[i].aa);
			endcase
		end
		@(negedge clk);
		pin_on = 0;

		for (int ph = 0; ph < PHASES; ph++) begin
			quiet_tail = (ph == PHASES - 1);
			set_reg(REG_BASE, (ph == 0) ? 32'hFFFF_FFF0 : pick_base());
			set_reg(REG_SIZE, (ph == 1) ? 32'd4096 : {19'd0, pick_pool()});
			issue(CMD_INIT, 13'($urandom), $urandom);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (!quiet_tail && $urandom_range(0, 5) == 0)
					pause($urandom_range(1, 11));
				r = $urandom_range(0, 99);
				if (r < 58) begin
					issue(CMD_ALLOC, pick_size(), $urandom);
				end else if (r < 92) begin
					a = $urandom;
					if (live.size() != 0 && $urandom_range(0, 9) < 8)
						a = live[$urandom_range(0, live.size() - 1)];
					else if ($urandom_range(0, 3) == 0)
						a = 32'd0;
					issue(CMD_FREE, 13'($urandom), a);
				end else if (r < 97) begin
					issue(CMD_INIT, 13'($urandom), $urandom);
				end else begin
					issue(CMD_DONE, 13'($urandom), $urandom);
				end
			end
		end

		@(negedge clk);
		start = 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
